/* design/hsibs_pkg.sv */
package hsibs_pkg;

  // Defaults of the top-level parameters.
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  // Hue, saturation and intensity; also the number of projection rows.
  localparam int N_CHAN = 3;

  // Request kinds carried in in_tuser.
  localparam int REQ_W = 2;
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR    = 2'd0,
    REQ_SAMPLE   = 2'd1,
    REQ_CLASSIFY = 2'd2
  } req_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_THREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 2'd3;

  localparam logic [N_CHAN-1:0] MASK_ALL = 3'b111;

  // Result pixel codes.
  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_INSIDE  = 8'd0;
  localparam logic [PIX_W-1:0] PIX_OUTSIDE = 8'd255;

endpackage

/* design/hsi_transform_box_segmenter_core.sv */
// Channel | Direction | tdata (low bit up)                  | tuser
// in_     | slave     | in_hue, in_sat, in_int, zero pad     | req_type
// out_    | master    | out_pixel                           | inside_flag
// cfg_    | write     | cfg_wdata: register value           | cfg_addr: register index
//
// One item is accepted per cycle unless a stalled output has backed up the pipeline. A
// classify item passes the input, product, sum and result registers to its result; the
// products of the 3x3 projection set the stage split.
// Clear and sample items update the running min/max at the transfer and give no result.
// A stalled output holds every stage that is full; empty stages still fill.
// Reset (rst_n low, synchronous) empties the pipeline, clears the statistics and
// sets the coefficients to zero and the component mask to all three.
module hsi_transform_box_segmenter_core
  import hsibs_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // in_hue, in_sat, in_int, zero pad
  input  logic [((N_CHAN*SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  // req_type
  input  logic [REQ_W-1:0]                              in_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // out_pixel
  output logic [PIX_W-1:0]                              out_tdata,
  // inside_flag
  output logic                                          out_tuser,
  input  logic                                          cfg_we,
  input  logic [CFG_IDX_W-1:0]                          cfg_addr,
  input  logic [N_CHAN*(COEF_FRAC_BITS+2)-1:0]          cfg_wdata
);

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int ROW_W     = N_CHAN * COEF_BITS;
  localparam int PROD_W    = COEF_BITS + SAMPLE_BITS;
  localparam int SUM_W     = PROD_W + 2;
  // Projected vectors: the pixel, the stored maxima and the stored minima.
  localparam int N_SRC     = 3;
  localparam int SRC_PIX   = 0;
  localparam int SRC_MAX   = 1;
  localparam int SRC_MIN   = 2;

  // Configuration
  logic [ROW_W-1:0]  coef_r [N_CHAN];
  logic [N_CHAN-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < N_CHAN; r++) coef_r[r] <= '0;
      mask_r <= MASK_ALL;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ROW_ONE:   coef_r[0] <= cfg_wdata;
        CFG_ROW_TWO:   coef_r[1] <= cfg_wdata;
        CFG_ROW_THREE: coef_r[2] <= cfg_wdata;
        CFG_MASK:      mask_r    <= cfg_wdata[N_CHAN-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic adv1, adv2, adv3, adv_o;
  logic in_xfer;

  assign adv_o     = !out_v_r || out_tready;
  assign adv3      = !s3_v_r || adv_o;
  assign adv2      = !s2_v_r || adv3;
  assign adv1      = !s1_v_r || adv2;
  assign in_tready = adv1;
  assign in_xfer   = in_tvalid && adv1;

  // Running statistics
  logic [SAMPLE_BITS-1:0] pix_in [N_CHAN];
  logic [SAMPLE_BITS-1:0] max_r  [N_CHAN];
  logic [SAMPLE_BITS-1:0] min_r  [N_CHAN];

  always_comb begin
    for (int c = 0; c < N_CHAN; c++) pix_in[c] = in_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < N_CHAN; c++) begin
        max_r[c] <= '0;
        min_r[c] <= '1;
      end
    end else if (in_xfer) begin
      case (in_tuser)
        REQ_CLEAR: begin
          for (int c = 0; c < N_CHAN; c++) begin
            max_r[c] <= '0;
            min_r[c] <= '1;
          end
        end
        REQ_SAMPLE: begin
          for (int c = 0; c < N_CHAN; c++) begin
            if (pix_in[c] > max_r[c]) max_r[c] <= pix_in[c];
            if (pix_in[c] < min_r[c]) min_r[c] <= pix_in[c];
          end
        end
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1)  s1_v_r  <= in_xfer && (in_tuser == REQ_CLASSIFY);
      if (adv2)  s2_v_r  <= s1_v_r;
      if (adv3)  s3_v_r  <= s2_v_r;
      if (adv_o) out_v_r <= s3_v_r;
    end
  end

  // Input register: the pixel together with the bounds as they stand at its transfer.
  logic [SAMPLE_BITS-1:0] src_r [N_SRC][N_CHAN];

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int c = 0; c < N_CHAN; c++) begin
        src_r[SRC_PIX][c] <= pix_in[c];
        src_r[SRC_MAX][c] <= max_r[c];
        src_r[SRC_MIN][c] <= min_r[c];
      end
    end
  end

  // Product register: every coefficient times its own channel of every vector.
  logic signed [PROD_W-1:0] prod_nxt [N_CHAN][N_SRC][N_CHAN];
  logic signed [PROD_W-1:0] prod_r   [N_CHAN][N_SRC][N_CHAN];

  always_comb begin
    for (int r = 0; r < N_CHAN; r++) begin
      for (int s = 0; s < N_SRC; s++) begin
        for (int c = 0; c < N_CHAN; c++) begin
          prod_nxt[r][s][c] = PROD_W'($signed(coef_r[r][c*COEF_BITS +: COEF_BITS])
                                      * $signed({1'b0, src_r[s][c]}));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) prod_r <= prod_nxt;
  end

  // Sum register: the projections, exact, with two guard bits.
  logic signed [SUM_W-1:0] sum_nxt [N_CHAN][N_SRC];
  logic signed [SUM_W-1:0] sum_r   [N_CHAN][N_SRC];

  always_comb begin
    for (int r = 0; r < N_CHAN; r++) begin
      for (int s = 0; s < N_SRC; s++) begin
        sum_nxt[r][s] = SUM_W'(prod_r[r][s][0]) + SUM_W'(prod_r[r][s][1])
                      + SUM_W'(prod_r[r][s][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) sum_r <= sum_nxt;
  end

  // Result register: order each bound pair and test the selected components.
  logic [N_CHAN-1:0]      mask_eff;
  logic [N_CHAN-1:0]      hit;
  logic                   inside_nxt;
  logic signed [SUM_W-1:0] lo, hi;
  logic [PIX_W-1:0]       out_pixel_r;
  logic                   inside_r;

  assign mask_eff = (mask_r == '0) ? MASK_ALL : mask_r;

  always_comb begin
    inside_nxt = 1'b1;
    for (int r = 0; r < N_CHAN; r++) begin
      lo = (sum_r[r][SRC_MAX] < sum_r[r][SRC_MIN]) ? sum_r[r][SRC_MAX] : sum_r[r][SRC_MIN];
      hi = (sum_r[r][SRC_MAX] < sum_r[r][SRC_MIN]) ? sum_r[r][SRC_MIN] : sum_r[r][SRC_MAX];
      hit[r] = (sum_r[r][SRC_PIX] >= lo) && (sum_r[r][SRC_PIX] <= hi);
      if (mask_eff[r] && !hit[r]) inside_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      inside_r    <= inside_nxt;
      out_pixel_r <= inside_nxt ? PIX_INSIDE : PIX_OUTSIDE;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pixel_r;
  assign out_tuser  = inside_r;

endmodule

/* design/hsibs_checker.sv */
module hsibs_checker
  import hsibs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [REQ_W-1:0] in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [PIX_W-1:0] out_tdata,
  input logic             out_tuser
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The pixel code and the inside flag always agree.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == PIX_INSIDE && out_tuser)
                || (out_tdata == PIX_OUTSIDE && !out_tuser))
    else $error("pixel code and inside flag disagree");

  // With the output side ready, a classify transfer shows its result once it has passed every pipeline register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_CLASSIFY
      ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("classify result missing");

endmodule

bind hsi_transform_box_segmenter_core hsibs_checker u_hsibs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* dv/tb_hsi_transform_box_segmenter_core.sv */
module tb_hsi_transform_box_segmenter_core import hsibs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SMP_W        = SAMPLE_BITS_DEF;
  localparam int COEF_W       = COEF_FRAC_BITS_DEF + 2;
  localparam int ROW_W        = N_CHAN * COEF_W;
  localparam int IN_W         = ((N_CHAN * SMP_W + 7) / 8) * 8;
  localparam int IDLE_PCT     = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int N_PHASES     = 6;
  localparam int CALM_PHASE   = 2;

  // Request code that the block must ignore.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef logic [N_CHAN-1:0][SMP_W-1:0] hsi_px_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             in_box;
  } verdict_t;

  typedef enum {SET_DIAG, SET_ALL_ONES, SET_EXTREME, SET_RANDOM, SET_ZERO} setup_kind_t;

  class box_classify_scoreboard;
    logic [ROW_W-1:0]  rows [N_CHAN];
    logic [N_CHAN-1:0] comp_mask;
    hsi_px_t           lo_seen;
    hsi_px_t           hi_seen;
    verdict_t          pending_verdicts [$];
    int                mismatches;
    int                n_inside;
    int                n_outside;

    function new();
      foreach (rows[r]) rows[r] = '0;
      comp_mask  = MASK_ALL;
      mismatches = 0;
      n_inside   = 0;
      n_outside  = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      lo_seen = '1;
      hi_seen = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
      case (idx)
        CFG_ROW_ONE:   rows[0] = value;
        CFG_ROW_TWO:   rows[1] = value;
        CFG_ROW_THREE: rows[2] = value;
        CFG_MASK:      comp_mask = value[N_CHAN-1:0];
        default: ;
      endcase
    endfunction

    // Full-precision dot product of one signed coefficient row with an unsigned pixel.
    function longint project(logic [ROW_W-1:0] row, hsi_px_t px);
      logic signed [COEF_W-1:0] coef;
      longint acc;
      acc = 0;
      for (int k = 0; k < N_CHAN; k++) begin
        coef = row[k*COEF_W +: COEF_W];
        acc += longint'(coef) * longint'({1'b0, px[k]});
      end
      return acc;
    endfunction

    function bit in_bound(logic [ROW_W-1:0] row, hsi_px_t px);
      longint x;
      longint a;
      longint b;
      x = project(row, px);
      a = project(row, hi_seen);
      b = project(row, lo_seen);
      return (a < b) ? (x >= a && x <= b) : (x >= b && x <= a);
    endfunction

    function verdict_t classify(hsi_px_t px);
      logic [N_CHAN-1:0] sel;
      verdict_t v;
      sel = (comp_mask == '0) ? MASK_ALL : comp_mask;
      v.in_box = 1'b1;
      for (int k = 0; k < N_CHAN; k++) begin
        if (sel[k] && !in_bound(rows[k], px)) v.in_box = 1'b0;
      end
      v.pixel = v.in_box ? PIX_INSIDE : PIX_OUTSIDE;
      return v;
    endfunction

    function void note_input(logic [REQ_W-1:0] req, hsi_px_t px);
      case (req)
        REQ_CLEAR: clear_stats();
        REQ_SAMPLE: begin
          for (int k = 0; k < N_CHAN; k++) begin
            if (px[k] > hi_seen[k]) hi_seen[k] = px[k];
            if (px[k] < lo_seen[k]) lo_seen[k] = px[k];
          end
        end
        REQ_CLASSIFY: pending_verdicts.push_back(classify(px));
        default: ;
      endcase
    endfunction

    function void check_result(logic [PIX_W-1:0] pixel, logic in_box);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, got pixel %0d flag %0b",
                 $time, pixel, in_box);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (pixel !== want.pixel) begin
        $display("%0t: out_pixel mismatch: expected %0d, got %0d", $time, want.pixel, pixel);
        mismatches++;
      end
      if (in_box !== want.in_box) begin
        $display("%0t: inside_flag mismatch: expected %0b, got %0b", $time, want.in_box,
                 in_box);
        mismatches++;
      end
      if (want.in_box) n_inside++;
      else n_outside++;
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic [REQ_W-1:0]  in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [PIX_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [ROW_W-1:0]  cfg_wdata  = '0;

  box_classify_scoreboard sb;
  bit idle_enable = 1'b1;
  int items_sent  = 0;
  int n_settings  = 0;
  int req_seen [4] = '{0, 0, 0, 0};

  setup_kind_t plan [N_PHASES] = '{SET_DIAG, SET_ALL_ONES, SET_EXTREME, SET_RANDOM, SET_ZERO,
                                   SET_RANDOM};

  hsi_transform_box_segmenter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = !idle_enable || ($urandom_range(99) >= IDLE_PCT);
  end

  // Results are checked before the input of the same edge is noted; a classify
  // transfer never produces its result at the edge it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tuser, in_tdata[N_CHAN*SMP_W-1:0]);
        req_seen[in_tuser]++;
      end
    end
  end

  function automatic hsi_px_t pack_px(logic [SMP_W-1:0] h, logic [SMP_W-1:0] s,
                                      logic [SMP_W-1:0] i);
    return {i, s, h};
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                                logic [COEF_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic hsi_px_t rand_px();
    hsi_px_t px;
    for (int k = 0; k < N_CHAN; k++) begin
      case ($urandom_range(15))
        0:       px[k] = '0;
        1:       px[k] = '1;
        default: px[k] = SMP_W'($urandom_range(0, 65535));
      endcase
    end
    return px;
  endfunction

  // Probe pixels: on the segment between the stored corners (rounded down per channel),
  // anywhere in the per-channel box, or anywhere at all.
  function automatic hsi_px_t pick_probe();
    hsi_px_t px;
    int unsigned t;
    int unsigned span;
    bit ordered;
    ordered = 1'b1;
    for (int k = 0; k < N_CHAN; k++) begin
      if (sb.hi_seen[k] < sb.lo_seen[k]) ordered = 1'b0;
    end
    px = rand_px();
    if (ordered) begin
      case ($urandom_range(2))
        0: begin
          t = $urandom_range(0, 256);
          for (int k = 0; k < N_CHAN; k++) begin
            span  = sb.hi_seen[k] - sb.lo_seen[k];
            px[k] = sb.lo_seen[k] + SMP_W'((span * t) >> 8);
          end
        end
        1: begin
          for (int k = 0; k < N_CHAN; k++) begin
            px[k] = SMP_W'($urandom_range(sb.lo_seen[k], sb.hi_seen[k]));
          end
        end
        default: ;
      endcase
    end
    return px;
  endfunction

  // Entered and left at a falling edge; tvalid stays high into the next item.
  task automatic send_item(logic [REQ_W-1:0] req, hsi_px_t px);
    while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = IN_W'(px);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (sb.pending_verdicts.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setup(logic [ROW_W-1:0] r1, logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3,
                            logic [ROW_W-1:0] mask_word);
    settle();
    write_reg(CFG_ROW_ONE, r1);
    write_reg(CFG_ROW_TWO, r2);
    write_reg(CFG_ROW_THREE, r3);
    write_reg(CFG_MASK, mask_word);
    n_settings++;
  endtask

  task automatic random_setup(setup_kind_t kind);
    logic [ROW_W-1:0] r [N_CHAN];
    logic [ROW_W-1:0] mword;
    mword = ROW_W'($urandom_range(0, 7));
    for (int k = 0; k < N_CHAN; k++) begin
      r[k] = ROW_W'({$urandom, $urandom});
      case (kind)
        SET_DIAG: begin
          r[k] = '0;
          r[k][k*COEF_W +: COEF_W] = COEF_W'($urandom_range(1, 16'h7FFF));
        end
        SET_ALL_ONES: r[k] = '1;
        SET_EXTREME: begin
          for (int c = 0; c < N_CHAN; c++) begin
            case ($urandom_range(2))
              0:       r[k][c*COEF_W +: COEF_W] = 16'h7FFF;
              1:       r[k][c*COEF_W +: COEF_W] = 16'h8000;
              default: r[k][c*COEF_W +: COEF_W] = '0;
            endcase
          end
        end
        SET_ZERO: r[k] = '0;
        default: ;
      endcase
    end
    case (kind)
      SET_DIAG, SET_ZERO: mword = ROW_W'(MASK_ALL);
      SET_ALL_ONES:       mword = '0;
      // Bits above the mask width must be dropped by the block.
      SET_RANDOM:         mword = ROW_W'({$urandom, $urandom});
      default: ;
    endcase
    load_setup(r[0], r[1], r[2], mword);
  endtask

  task automatic run_phase(int quota);
    int target;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(3) != 0) send_item(REQ_CLEAR, rand_px());
        repeat ($urandom_range(1, 6)) send_item(REQ_SAMPLE, rand_px());
        repeat ($urandom_range(1, 8)) send_item(REQ_CLASSIFY, pick_probe());
      end else begin
        repeat ($urandom_range(1, 4)) send_item(REQ_W'($urandom_range(0, 3)), pick_probe());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: zero coefficients put every pixel inside.
    send_item(REQ_CLASSIFY, pack_px(16'h0000, 16'h0000, 16'h0000));
    send_item(REQ_CLASSIFY, pack_px(16'hFFFF, 16'hFFFF, 16'hFFFF));

    // Identity rows so each component is one channel.
    load_setup(pack_row(16'h4000, 16'h0000, 16'h0000), pack_row(16'h0000, 16'h4000, 16'h0000),
               pack_row(16'h0000, 16'h0000, 16'h4000), ROW_W'(MASK_ALL));
    // No samples yet: bounds come from the reset corners.
    send_item(REQ_CLASSIFY, pack_px(16'h1234, 16'h5678, 16'h9ABC));
    send_item(REQ_CLEAR, pack_px(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(REQ_CLASSIFY, pack_px(16'h0000, 16'h0000, 16'h0000));
    send_item(REQ_SAMPLE, pack_px(16'h1000, 16'h2000, 16'h3000));
    send_item(REQ_SAMPLE, pack_px(16'h8000, 16'h9000, 16'hA000));
    send_item(REQ_CLASSIFY, pack_px(16'h4000, 16'h5000, 16'h6000));
    send_item(REQ_CLASSIFY, pack_px(16'h1000, 16'h2000, 16'h3000));
    send_item(REQ_CLASSIFY, pack_px(16'h8000, 16'h9000, 16'hA000));
    send_item(REQ_CLASSIFY, pack_px(16'h0FFF, 16'h5000, 16'h6000));
    send_item(REQ_CLASSIFY, pack_px(16'h4000, 16'h9001, 16'h6000));
    send_item(REQ_CLASSIFY, pack_px(16'h4000, 16'h5000, 16'hA001));
    // The unused code must not widen the box.
    send_item(REQ_UNUSED, pack_px(16'h0000, 16'h0000, 16'h0000));
    send_item(REQ_CLASSIFY, pack_px(16'h0FFF, 16'h1FFF, 16'h2FFF));
    send_item(REQ_SAMPLE, pack_px(16'h0000, 16'hFFFF, 16'h0000));
    send_item(REQ_SAMPLE, pack_px(16'hFFFF, 16'h0000, 16'hFFFF));
    send_item(REQ_CLASSIFY, pack_px(16'hFFFF, 16'hFFFF, 16'hFFFF));

    // A zero mask tests all three components.
    settle();
    write_reg(CFG_MASK, '0);
    n_settings++;
    send_item(REQ_CLEAR, pack_px(16'h0000, 16'h0000, 16'h0000));
    send_item(REQ_SAMPLE, pack_px(16'h1000, 16'h1000, 16'h1000));
    send_item(REQ_SAMPLE, pack_px(16'h2000, 16'h2000, 16'h2000));
    send_item(REQ_CLASSIFY, pack_px(16'h1800, 16'h1800, 16'h2001));

    settle();
    write_reg(CFG_MASK, ROW_W'(3'b001));
    n_settings++;
    send_item(REQ_CLASSIFY, pack_px(16'h1800, 16'h1800, 16'h2001));

    // Most negative and most positive coefficients in one row.
    settle();
    write_reg(CFG_ROW_ONE, pack_row(16'h8000, 16'h7FFF, 16'h8000));
    n_settings++;
    send_item(REQ_CLASSIFY, pack_px(16'h1800, 16'h1800, 16'h1800));
    send_item(REQ_CLASSIFY, pack_px(16'hFFFF, 16'h0000, 16'hFFFF));

    for (int p = 0; p < N_PHASES; p++) begin
      random_setup(plan[p]);
      idle_enable = (p != CALM_PHASE);
      run_phase(PHASE_ITEMS);
    end
    idle_enable = 1'b1;
    settle();

    $display("Covered %0d clear, %0d sample, %0d classify and %0d unused-code transfers",
             req_seen[REQ_CLEAR], req_seen[REQ_SAMPLE], req_seen[REQ_CLASSIFY],
             req_seen[REQ_UNUSED]);
    $display("over %0d register settings; %0d inside and %0d outside results, %0d mismatches.",
             n_settings, sb.n_inside, sb.n_outside, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout: stimulus or results did not complete.");
    $display("TB_ERROR");
    $finish;
  end

endmodule
